// ----- hw/rtl/uer_pkg.sv -----
// Shared types and constants for the ultrasonic echo ranger.
`default_nettype none

package uer_pkg;

  // Measurement phase, one-hot coded.
  typedef enum logic [3:0] {
    PhIdle = 4'b0001,
    PhTrig = 4'b0010,
    PhWait = 4'b0100,
    PhEcho = 4'b1000
  } phase_e;

  // Result status codes.
  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StTimeout = 2'd1,
    StRange   = 2'd2
  } status_e;

  // Configuration register indexes.
  localparam logic [1:0] RegMaxDist = 2'd0;
  localparam logic [1:0] RegMinDist = 2'd1;
  localparam logic [1:0] RegTrigLen = 2'd2;
  localparam logic [1:0] RegTimeout = 2'd3;

  // Field widths.
  localparam int unsigned DistW  = 14;
  localparam int unsigned PulseW = 8;
  localparam int unsigned CountW = 16;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgAddrW = 2;

  // Register reset values.
  localparam logic [DistW-1:0]  MaxDistRst = 14'd4000;
  localparam logic [DistW-1:0]  MinDistRst = 14'd20;
  localparam logic [PulseW-1:0] TrigLenRst = 8'd10;
  localparam logic [CountW-1:0] TimeoutRst = 16'd30000;

  // Saturation limit of the tick counters.
  localparam logic [CountW-1:0] CountMax = 16'hFFFF;

  // count * 10 / 58 == count * 5 / 29, done as a multiply by the scaled
  // reciprocal ceil(5 * 2^24 / 29) and a shift by 24. The rounding error is
  // 16 per unit of count, well below 2^24 for any 16-bit count, so the
  // quotient is exact.
  localparam int unsigned DivShift = 24;
  localparam int unsigned DivKW    = 22;
  localparam logic [DivKW-1:0] DivK = 22'd2892624;
  localparam int unsigned ProdW    = CountW + DivKW;

  // Packed result fields that travel in tdata, highest bit first.
  typedef struct packed {
    logic             good_flag;
    logic [DistW-1:0] good_dist;
    logic [DistW-1:0] meas_mm;
    status_e          status;
    logic             trig;
  } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ultrasonic_echo_ranger_core.sv -----
// Top level of the ultrasonic echo ranger: tick sequencer and distance check.
`default_nettype none

// One input item is one microsecond tick carrying a start request and the
// sampled echo pin level; every item gives exactly one result item with the
// trigger pin level, a done flag (on tlast), status, distance and the last
// good distance. The block takes one item per clock cycle while the output is
// not held by backpressure: an item passes an input register, then one stage of
// logic (the phase sequencer, the tick counters and one constant multiply for
// the millimetre conversion) updates the state and loads the result register.
// Both registers hold their item under backpressure and refill in the cycle
// they are emptied. Configuration is written through a simple write port and
// takes effect on the next edge.
module ultrasonic_echo_ranger_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration write port.
  input  wire logic                          cfg_we_i,
  input  wire logic [uer_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  wire logic [uer_pkg::CfgW-1:0]      cfg_wdata_i,
  // Input items.
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,  // [0] start_req, [1] echo_level, [7:2] zero
  // Result items.
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output      logic [31:0] m_axis_tdata_o,  // [0] trigger_out, [2:1] status,
                                            // [16:3] meas_mm, [30:17] last_good_mm,
                                            // [31] last_good_valid
  output      logic        m_axis_tlast_o   // done_res
);

  // Configuration registers.
  logic [uer_pkg::DistW-1:0]  max_dist_q;
  logic [uer_pkg::DistW-1:0]  min_dist_q;
  logic [uer_pkg::PulseW-1:0] trig_len_q;
  logic [uer_pkg::CountW-1:0] timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dist_q <= uer_pkg::MaxDistRst;
      min_dist_q <= uer_pkg::MinDistRst;
      trig_len_q <= uer_pkg::TrigLenRst;
      timeout_q  <= uer_pkg::TimeoutRst;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        uer_pkg::RegMaxDist: max_dist_q <= cfg_wdata_i[uer_pkg::DistW-1:0];
        uer_pkg::RegMinDist: min_dist_q <= cfg_wdata_i[uer_pkg::DistW-1:0];
        uer_pkg::RegTrigLen: trig_len_q <= cfg_wdata_i[uer_pkg::PulseW-1:0];
        uer_pkg::RegTimeout: timeout_q  <= cfg_wdata_i[uer_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake: each register takes a new item when it is empty or
  // when its current item moves on.
  logic in_valid_q;
  logic out_valid_q;
  logic out_ready;
  logic in_ready;
  logic advance;

  assign out_ready       = !out_valid_q || m_axis_tready_i;
  assign in_ready        = !in_valid_q || out_ready;
  assign advance         = in_valid_q && out_ready;
  assign s_axis_tready_o = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (out_ready) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Input register payload.
  logic in_start_q;
  logic in_echo_q;

  always_ff @(posedge clk_i) begin
    if (in_ready && s_axis_tvalid_i) begin
      in_start_q <= s_axis_tdata_i[0];
      in_echo_q  <= s_axis_tdata_i[1];
    end
  end

  // Measurement state.
  uer_pkg::phase_e            phase_q, phase_d;
  logic [uer_pkg::PulseW-1:0] pulse_q, pulse_d;
  logic [uer_pkg::CountW-1:0] wait_q, wait_d;
  logic [uer_pkg::CountW-1:0] echo_q, echo_d;
  logic [uer_pkg::DistW-1:0]  good_dist_q, good_dist_d;
  logic                       good_flag_q, good_flag_d;

  // Distance conversion of the current echo count.
  logic [uer_pkg::ProdW-1:0] prod;
  logic [uer_pkg::DistW-1:0] echo_dist;

  assign prod      = uer_pkg::ProdW'(echo_q) * uer_pkg::ProdW'(uer_pkg::DivK);
  assign echo_dist = prod[uer_pkg::DivShift +: uer_pkg::DistW];

  uer_pkg::result_t res_d;
  logic             done_d;

  // Next state and result for the item in the input register.
  always_comb begin
    phase_d     = phase_q;
    pulse_d     = pulse_q;
    wait_d      = wait_q;
    echo_d      = echo_q;
    good_dist_d = good_dist_q;
    good_flag_d = good_flag_q;
    done_d      = 1'b0;
    res_d.trig    = 1'b0;
    res_d.status  = uer_pkg::StOk;
    res_d.meas_mm = '0;

    case (phase_q)
      uer_pkg::PhIdle: begin
        if (in_start_q) begin
          res_d.trig = 1'b1;
          pulse_d    = uer_pkg::PulseW'(1);
          phase_d    = uer_pkg::PhTrig;
        end
      end
      uer_pkg::PhTrig: begin
        if (pulse_q >= trig_len_q) begin
          phase_d = uer_pkg::PhWait;
          wait_d  = '0;
          echo_d  = '0;
          pulse_d = '0;
        end else begin
          res_d.trig = 1'b1;
          pulse_d    = pulse_q + uer_pkg::PulseW'(1);
        end
      end
      default: begin
        // Waiting for or timing the echo.
        if (wait_q != uer_pkg::CountMax) begin
          wait_d = wait_q + uer_pkg::CountW'(1);
        end
        if (in_echo_q) begin
          if (echo_q != uer_pkg::CountMax) begin
            echo_d = echo_q + uer_pkg::CountW'(1);
          end
          phase_d = uer_pkg::PhEcho;
        end
        if (phase_q == uer_pkg::PhEcho && !in_echo_q) begin
          // Echo fell: convert and range-check.
          done_d        = 1'b1;
          res_d.meas_mm = echo_dist;
          if (echo_dist > max_dist_q || echo_dist < min_dist_q) begin
            res_d.status = uer_pkg::StRange;
            good_flag_d  = 1'b0;
          end else begin
            res_d.status = uer_pkg::StOk;
            good_dist_d  = echo_dist;
            good_flag_d  = 1'b1;
          end
          phase_d = uer_pkg::PhIdle;
        end else if (wait_d >= timeout_q) begin
          done_d       = 1'b1;
          res_d.status = uer_pkg::StTimeout;
          good_flag_d  = 1'b0;
          phase_d      = uer_pkg::PhIdle;
        end
      end
    endcase

    res_d.good_dist = good_dist_d;
    res_d.good_flag = good_flag_d;
  end

  // State registers advance once per item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= uer_pkg::PhIdle;
      pulse_q     <= '0;
      wait_q      <= '0;
      echo_q      <= '0;
      good_dist_q <= '0;
      good_flag_q <= 1'b0;
    end else if (advance) begin
      phase_q     <= phase_d;
      pulse_q     <= pulse_d;
      wait_q      <= wait_d;
      echo_q      <= echo_d;
      good_dist_q <= good_dist_d;
      good_flag_q <= good_flag_d;
    end
  end

  // Result register.
  uer_pkg::result_t res_q;
  logic             done_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q  <= res_d;
      done_q <= done_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = res_q;
  assign m_axis_tlast_o  = done_q;

endmodule

`default_nettype wire
